FILE: sv/bsle_pkg.sv
// Shared types and constants for the bounded sorted list engine.
// Used by the core, the port checker and the testbench; no dependencies.
package bsle_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_CAPACITY     = 32;
    localparam int DEF_PAYLOAD_BITS = 32;

    // Fixed field widths of the stream items.
    localparam int CMD_BITS         = 3;
    localparam int KEY_BITS         = 32;
    localparam int PAYLOAD_IN_BITS  = 32;
    localparam int STATUS_BITS      = 2;
    localparam int COUNT_OUT_BITS   = 6;

    // Packed stream widths, rounded up to whole bytes.
    localparam int IN_FIELD_BITS    = CMD_BITS + KEY_BITS + PAYLOAD_IN_BITS;
    localparam int IN_TDATA_W       = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS   = STATUS_BITS + COUNT_OUT_BITS + 2;
    localparam int OUT_TDATA_W      = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Bit positions inside the result tdata.
    localparam int OUT_COUNT_LSB    = STATUS_BITS;
    localparam int OUT_FULL_BIT     = STATUS_BITS + COUNT_OUT_BITS;
    localparam int OUT_EMPTY_BIT    = STATUS_BITS + COUNT_OUT_BITS + 1;

    // List commands.
    typedef enum logic [CMD_BITS-1:0] {
        CMD_TAIL_INS = 3'd0,
        CMD_HEAD_INS = 3'd1,
        CMD_SORT_INS = 3'd2,
        CMD_TAIL_REM = 3'd3,
        CMD_HEAD_REM = 3'd4,
        CMD_KEY_REM  = 3'd5
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

endpackage

FILE: sv/bsle_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the list records; no package dependencies.
module bsle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/bounded_sorted_list_engine_core.sv
// Bounded sorted list engine: a fixed-capacity list of key/payload records in one RAM.
// Depends on bsle_pkg and bsle_ram.
//
// One command is taken at a time. Tail insert, tail remove, the unused command codes and
// refused commands go from the accepting transfer straight to the final state, which
// loads the output register once it is free. Head insert, sorted insert, head remove and
// remove-by-key make one forward pass over the held entries through the record RAM,
// reading one entry a cycle and writing the shifted entry behind the read pointer, then
// reach the final state; head remove starts its pass at the second entry. A new command
// is accepted while the previous result still waits in the output register; the memory
// holds no state that needs clearing after reset.
module bounded_sorted_list_engine_core #(
    parameter int CAPACITY     = bsle_pkg::DEF_CAPACITY,
    parameter int PAYLOAD_BITS = bsle_pkg::DEF_PAYLOAD_BITS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: command [2:0], key [34:3], payload [66:35], zero fill above
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [bsle_pkg::IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: status [1:0], entry_count [7:2], is_full [8], is_empty [9], zero fill above
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [bsle_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import bsle_pkg::*;

    localparam int IW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int REC_W = KEY_BITS + PAYLOAD_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FINAL
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INS,
        OP_REM
    } op_t;

    state_t               state_reg;
    op_t                  op_reg;
    cmd_t                 cmd_reg;
    status_t              status_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [REC_W-1:0]     carry_reg;
    logic                 found_reg;
    logic [CW-1:0]        rd_idx_reg;
    logic                 pend_reg;
    logic [IW-1:0]        pend_idx_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    // Input field split.
    cmd_t                       in_cmd;
    logic [KEY_BITS-1:0]        in_key;
    logic [PAYLOAD_IN_BITS-1:0] in_payload;
    logic [PAYLOAD_BITS-1:0]    in_pl_kept;

    assign in_cmd     = cmd_t'(s_tdata[CMD_BITS-1:0]);
    assign in_key     = s_tdata[CMD_BITS +: KEY_BITS];
    assign in_payload = s_tdata[CMD_BITS + KEY_BITS +: PAYLOAD_IN_BITS];

    // Stored payload is the input payload cut or zero-extended to PAYLOAD_BITS.
    if (PAYLOAD_BITS <= PAYLOAD_IN_BITS) begin : g_pl_trunc
        assign in_pl_kept = in_payload[PAYLOAD_BITS-1:0];
    end else begin : g_pl_ext
        assign in_pl_kept = {{(PAYLOAD_BITS - PAYLOAD_IN_BITS){1'b0}}, in_payload};
    end

    // Record RAM.
    logic             ram_we;
    logic [IW-1:0]    ram_waddr;
    logic [REC_W-1:0] ram_wdata;
    logic             ram_re;
    logic [REC_W-1:0] ram_rdata;
    logic [KEY_BITS-1:0] rd_key;

    bsle_ram #(
        .WIDTH (REC_W),
        .DEPTH (CAPACITY)
    ) u_rec_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    assign rd_key = ram_rdata[REC_W-1 -: KEY_BITS];

    // Status of the list at accept time and at the end of a command.
    logic          list_full;
    logic          list_empty;
    logic          out_free;
    logic          sweep_done;
    logic          ins_hit;
    logic          rem_match;
    logic [CW-1:0] cnt_fin;
    status_t       status_fin;
    logic [COUNT_OUT_BITS-1:0] cnt_fin_out;

    // Decode of the offered command and the result register load.
    state_t                 acc_state;
    op_t                    acc_op;
    status_t                acc_status;
    logic                   acc_found;
    logic [CW-1:0]          acc_rd_idx;
    logic                   result_load;
    logic                   m_valid_next;
    logic [OUT_TDATA_W-1:0] m_data_next;

    assign list_full  = (cnt_reg == CW'(CAPACITY));
    assign list_empty = (cnt_reg == '0);
    assign out_free   = !m_valid_reg || m_tready;
    assign sweep_done = (rd_idx_reg == cnt_reg) && !pend_reg;
    assign ins_hit    = found_reg || ((cmd_reg == CMD_SORT_INS) && (rd_key <= key_reg));
    assign rem_match  = (cmd_reg == CMD_KEY_REM) && (rd_key == key_reg);

    // Reads run ahead of writes by one entry, so a read never meets a pending
    // write to the same address.
    assign ram_re = (state_reg == S_SWEEP) && (rd_idx_reg != cnt_reg);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pend_idx_reg;
        ram_wdata = carry_reg;
        if (state_reg == S_SWEEP && pend_reg) begin
            if (op_reg == OP_INS && ins_hit) begin
                // Put the carried record here and pick up the one it displaces.
                ram_we = 1'b1;
            end else if (op_reg == OP_REM && found_reg) begin
                // Move the entry down over the removed one.
                ram_we    = 1'b1;
                ram_waddr = IW'(pend_idx_reg - 1'b1);
                ram_wdata = ram_rdata;
            end
        end else if (state_reg == S_FINAL && op_reg == OP_INS && out_free) begin
            // The last carried record lands in the first free slot, just past the old tail.
            ram_we    = 1'b1;
            ram_waddr = cnt_reg[IW-1:0];
        end
    end

    // What an accepted command sets up: refusals go straight to the result.
    always_comb begin
        acc_state  = S_FINAL;
        acc_op     = OP_NONE;
        acc_status = ST_DONE;
        acc_found  = 1'b0;
        acc_rd_idx = '0;
        case (in_cmd)
            CMD_TAIL_INS, CMD_HEAD_INS, CMD_SORT_INS: begin
                if (list_full) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_op    = OP_INS;
                    acc_found = (in_cmd == CMD_HEAD_INS);
                    if (in_cmd != CMD_TAIL_INS) begin
                        acc_state = S_SWEEP;
                    end
                end
            end
            CMD_TAIL_REM, CMD_HEAD_REM, CMD_KEY_REM: begin
                if (list_empty) begin
                    acc_status = ST_EMPTY;
                end else begin
                    acc_op    = OP_REM;
                    acc_found = (in_cmd != CMD_KEY_REM);
                    if (in_cmd == CMD_HEAD_REM) begin
                        acc_rd_idx = CW'(1);
                        acc_state  = S_SWEEP;
                    end else if (in_cmd == CMD_KEY_REM) begin
                        acc_state  = S_SWEEP;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Count and status at the end of the command.
    always_comb begin
        cnt_fin    = cnt_reg;
        status_fin = status_reg;
        case (op_reg)
            OP_INS: begin
                cnt_fin = CW'(cnt_reg + 1'b1);
            end
            OP_REM: begin
                if (found_reg) begin
                    cnt_fin = CW'(cnt_reg - 1'b1);
                end else begin
                    status_fin = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    if (CW >= COUNT_OUT_BITS) begin : g_cnt_trunc
        assign cnt_fin_out = cnt_fin[COUNT_OUT_BITS-1:0];
    end else begin : g_cnt_ext
        assign cnt_fin_out = {{(COUNT_OUT_BITS - CW){1'b0}}, cnt_fin};
    end

    // Result word and output valid for the next cycle.
    always_comb begin
        m_data_next = '0;
        m_data_next[STATUS_BITS-1:0] = status_fin;
        m_data_next[OUT_COUNT_LSB +: COUNT_OUT_BITS] = cnt_fin_out;
        m_data_next[OUT_FULL_BIT]  = (cnt_fin == CW'(CAPACITY));
        m_data_next[OUT_EMPTY_BIT] = (cnt_fin == '0);
    end

    assign result_load  = (state_reg == S_FINAL) && out_free;
    assign m_valid_next = result_load || (m_valid_reg && !m_tready);

    // Command sequencer with the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_NONE;
            found_reg   <= 1'b0;
            pend_reg    <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        cmd_reg    <= in_cmd;
                        key_reg    <= in_key;
                        carry_reg  <= {in_key, in_pl_kept};
                        status_reg <= acc_status;
                        rd_idx_reg <= acc_rd_idx;
                        pend_reg   <= 1'b0;
                        found_reg  <= acc_found;
                        op_reg     <= acc_op;
                        state_reg  <= acc_state;
                    end
                end

                S_SWEEP: begin
                    // Issue side.
                    pend_reg <= ram_re;
                    if (ram_re) begin
                        pend_idx_reg <= rd_idx_reg[IW-1:0];
                        rd_idx_reg   <= CW'(rd_idx_reg + 1'b1);
                    end
                    // Return side.
                    if (pend_reg) begin
                        if (op_reg == OP_INS && ins_hit) begin
                            carry_reg <= ram_rdata;
                            found_reg <= 1'b1;
                        end else if (op_reg == OP_REM && !found_reg && rem_match) begin
                            found_reg <= 1'b1;
                        end
                    end
                    if (sweep_done) begin
                        state_reg <= S_FINAL;
                    end
                end

                S_FINAL: begin
                    if (out_free) begin
                        cnt_reg    <= cnt_fin;
                        m_data_reg <= m_data_next;
                        state_reg  <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: sv/bsle_checker.sv
// Port-level checker for the bounded sorted list engine, bound to the top level.
// Depends on bsle_pkg.
module bsle_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [bsle_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import bsle_pkg::*;

    logic [STATUS_BITS-1:0]    chk_status;
    logic [COUNT_OUT_BITS-1:0] chk_count;
    logic                      chk_full;
    logic                      chk_empty;

    assign chk_status = m_tdata[STATUS_BITS-1:0];
    assign chk_count  = m_tdata[OUT_COUNT_LSB +: COUNT_OUT_BITS];
    assign chk_full   = m_tdata[OUT_FULL_BIT];
    assign chk_empty  = m_tdata[OUT_EMPTY_BIT];

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result transfer holds its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A refused insert reports a full list, a refused removal an empty one.
    a_full_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_status == ST_FULL) |-> chk_full && !chk_empty)
        else $error("full refusal without full flag");

    a_empty_refusal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (chk_status == ST_EMPTY) |-> chk_empty && (chk_count == '0))
        else $error("empty refusal without empty flag");

    // An empty list always shows a zero count.
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && chk_empty |-> (chk_count == '0) && !chk_full)
        else $error("empty flag with nonzero count");

endmodule

bind bounded_sorted_list_engine_core bsle_checker u_bsle_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/bounded_sorted_list_engine_core_test.sv
// Self-checking testbench for bounded_sorted_list_engine_core: drives list commands on the
// input stream, predicts every result from its own list model and checks each result transfer.
// Depends on bsle_pkg and the core RTL.
module bounded_sorted_list_engine_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bsle_pkg::*;

    localparam int LIST_DEPTH     = DEF_CAPACITY;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int SETTLE_CYCLES  = LIST_DEPTH + 16;
    localparam int IDLE_PCT       = 26;

    // Command codes the block treats as no operation.
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI = 3'd7;

    localparam logic [KEY_BITS-1:0] KEY_MAX = 32'hFFFF_FFFF;
    localparam logic [KEY_BITS-1:0] KEY_MID = 32'h8000_0000;

    // Fields of one result transfer.
    typedef struct {
        logic [STATUS_BITS-1:0]    status;
        logic [COUNT_OUT_BITS-1:0] entry_count;
        logic                      is_full;
        logic                      is_empty;
    } list_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Model of the list contents; payloads never show up in a result, so only keys are kept.
    logic [KEY_BITS-1:0] model_keys [LIST_DEPTH];
    int                  model_count;

    list_result_t        pending_results [$];

    int  error_count;
    int  results_checked;
    int  commands_by_code [8];
    int  status_seen [4];
    int  peak_occupancy;
    bit  steady_mode;
    bit  hold_request;

    bounded_sorted_list_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 4 ns period.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Apply one command to the list model and return the result it must produce.
    function automatic list_result_t predict_list_result(logic [CMD_BITS-1:0] cmd,
                                                         logic [KEY_BITS-1:0] key);
        list_result_t r;
        status_t      st;
        int           pos;
        int           i;
        st  = ST_DONE;
        pos = 0;
        case (cmd)
            CMD_TAIL_INS, CMD_HEAD_INS, CMD_SORT_INS: begin
                if (model_count >= LIST_DEPTH) begin
                    st = ST_FULL;
                end else begin
                    if (cmd == CMD_TAIL_INS) begin
                        pos = model_count;
                    end else if (cmd == CMD_SORT_INS) begin
                        // Skip every entry with a strictly greater key.
                        while (pos < model_count && model_keys[pos] > key) pos++;
                    end
                    for (i = model_count; i > pos; i--) model_keys[i] = model_keys[i-1];
                    model_keys[pos] = key;
                    model_count++;
                end
            end
            CMD_TAIL_REM, CMD_HEAD_REM, CMD_KEY_REM: begin
                if (model_count == 0) begin
                    st = ST_EMPTY;
                end else begin
                    if (cmd == CMD_TAIL_REM) begin
                        pos = model_count - 1;
                    end else if (cmd == CMD_KEY_REM) begin
                        // Only the first matching entry goes.
                        while (pos < model_count && model_keys[pos] != key) pos++;
                    end
                    if (pos >= model_count) begin
                        st = ST_NOT_FOUND;
                    end else begin
                        for (i = pos; i + 1 < model_count; i++) model_keys[i] = model_keys[i+1];
                        model_count--;
                    end
                end
            end
            default: begin
            end
        endcase
        if (model_count > peak_occupancy) peak_occupancy = model_count;
        status_seen[st]++;
        r.status      = st;
        r.entry_count = COUNT_OUT_BITS'(model_count);
        r.is_full     = (model_count == LIST_DEPTH);
        r.is_empty    = (model_count == 0);
        return r;
    endfunction

    // Offer one command until the block takes it, then record what it must answer.
    task automatic push_list_command(input logic [CMD_BITS-1:0] cmd,
                                     input logic [KEY_BITS-1:0] key,
                                     input logic [PAYLOAD_IN_BITS-1:0] payload);
        while (!steady_mode && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({payload, key, cmd});
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_list_result(cmd, key));
        commands_by_code[cmd]++;
    endtask

    // Keys are drawn mostly from a small pool so that duplicates and matches are common.
    function automatic logic [KEY_BITS-1:0] pick_key(logic [CMD_BITS-1:0] cmd);
        int pick;
        pick = $urandom_range(99);
        if (cmd == CMD_KEY_REM && model_count > 0 && pick < 70)
            return model_keys[$urandom_range(model_count - 1)];
        pick = $urandom_range(99);
        if (pick < 50) return KEY_BITS'($urandom_range(15));
        if (pick < 60) begin
            case ($urandom_range(3))
                0: return '0;
                1: return KEY_MAX;
                2: return KEY_MID;
                default: return KEY_MID - 1;
            endcase
        end
        return $urandom;
    endfunction

    // One random command; insert_pct sets how strongly the list grows.
    task automatic push_random_command(input int insert_pct);
        logic [CMD_BITS-1:0] cmd;
        int                  pick;
        pick = $urandom_range(99);
        if (pick < 4)
            cmd = (pick < 2) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
        else if (pick < 4 + insert_pct)
            cmd = CMD_BITS'($urandom_range(2));
        else
            cmd = CMD_BITS'(3 + $urandom_range(2));
        push_list_command(cmd, pick_key(cmd), $urandom);
    endtask

    // Every removal command on an empty list, and both unused codes.
    task automatic test_empty_list_refusals;
        push_list_command(CMD_TAIL_REM, '0, '0);
        push_list_command(CMD_HEAD_REM, KEY_MAX, KEY_MAX);
        push_list_command(CMD_KEY_REM, KEY_MID, '0);
        push_list_command(CMD_UNUSED_LO, KEY_MAX, '0);
        push_list_command(CMD_UNUSED_HI, '0, KEY_MAX);
    endtask

    // Insert positions, equal keys, duplicates and key misses on a short list.
    task automatic test_insert_and_remove_orders;
        push_list_command(CMD_TAIL_INS, '0, '0);
        push_list_command(CMD_HEAD_INS, KEY_MAX, 32'hFFFF_FFFF);
        push_list_command(CMD_SORT_INS, KEY_MID, 32'h1234_5678);
        // An equal key goes in front of the entry already held.
        push_list_command(CMD_SORT_INS, KEY_MID, 32'h8765_4321);
        push_list_command(CMD_SORT_INS, 32'd1, 32'h0000_0001);
        push_list_command(CMD_SORT_INS, '0, 32'h5555_5555);
        push_list_command(CMD_SORT_INS, KEY_MAX, 32'hAAAA_AAAA);
        push_list_command(CMD_UNUSED_HI, 32'd7, 32'd7);
        push_list_command(CMD_KEY_REM, 32'h0001_2345, '0);
        // With duplicates only the first match is removed.
        push_list_command(CMD_KEY_REM, KEY_MID, '0);
        push_list_command(CMD_KEY_REM, '0, '0);
        push_list_command(CMD_HEAD_REM, '0, '0);
        push_list_command(CMD_TAIL_REM, '0, '0);
        push_list_command(CMD_KEY_REM, KEY_MID, '0);
        push_list_command(CMD_KEY_REM, KEY_MAX, '0);
        push_list_command(CMD_KEY_REM, 32'd1, '0);
        push_list_command(CMD_TAIL_REM, '0, '0);
    endtask

    // Fill to capacity, get every insert refused, then drain back to empty.
    task automatic test_fill_and_drain;
        logic [CMD_BITS-1:0] cmd;
        while (model_count < LIST_DEPTH) begin
            cmd = CMD_BITS'($urandom_range(2));
            push_list_command(cmd, pick_key(cmd), $urandom);
        end
        push_list_command(CMD_TAIL_INS, $urandom, $urandom);
        push_list_command(CMD_HEAD_INS, $urandom, $urandom);
        push_list_command(CMD_SORT_INS, KEY_MAX, $urandom);
        push_list_command(CMD_UNUSED_LO, $urandom, $urandom);
        while (model_count > 0) begin
            cmd = CMD_BITS'(3 + $urandom_range(2));
            push_list_command(cmd, pick_key(cmd), $urandom);
        end
        push_list_command(CMD_KEY_REM, '0, '0);
    endtask

    // The receiver stops taking results while commands keep coming, so the input stalls.
    task automatic test_receiver_hold_off;
        hold_request = 1'b1;
        repeat (10) push_random_command(60);
    endtask

    // A long stretch with both sides always ready.
    task automatic test_steady_burst;
        steady_mode = 1'b1;
        repeat (60) push_random_command(50);
        steady_mode = 1'b0;
    endtask

    // Phases that alternately grow and shrink the list, so it sweeps between empty and full.
    task automatic test_random_walk;
        int phase;
        for (phase = 0; phase < 5; phase++) begin
            repeat (60) push_random_command((phase % 2 == 0) ? 75 : 20);
        end
    endtask

    // Wait for every expected result, then let the bench settle to catch strays.
    task automatic wait_for_drain;
        int waited;
        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
            error_count++;
        end
    endtask

    task automatic compare_field(input string name, input int expected_v, input int actual_v);
        if (expected_v != actual_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, expected_v, actual_v);
            error_count++;
        end
    endtask

    // Receiver ready: random idling, a counted hold-off on request, always ready when steady.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
            end else if (steady_mode) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Check each result transfer against the oldest expectation.
    initial begin
        list_result_t exp_r;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, actual %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    compare_field("status", int'(exp_r.status),
                                  int'(m_tdata[STATUS_BITS-1:0]));
                    compare_field("entry_count", int'(exp_r.entry_count),
                                  int'(m_tdata[OUT_COUNT_LSB +: COUNT_OUT_BITS]));
                    compare_field("is_full", int'(exp_r.is_full), int'(m_tdata[OUT_FULL_BIT]));
                    compare_field("is_empty", int'(exp_r.is_empty),
                                  int'(m_tdata[OUT_EMPTY_BIT]));
                    results_checked++;
                end
            end
        end
    end

    // Run limit, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Test sequence.
    initial begin
        error_count    = 0;
        results_checked = 0;
        model_count    = 0;
        peak_occupancy = 0;
        steady_mode    = 1'b0;
        hold_request   = 1'b0;
        foreach (commands_by_code[i]) commands_by_code[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_list_refusals();
        test_insert_and_remove_orders();
        test_fill_and_drain();
        test_receiver_hold_off();
        test_steady_burst();
        test_random_walk();
        s_tvalid <= 1'b0;
        wait_for_drain();

        $write("Ran %0d tail, %0d head, %0d sorted inserts; ",
               commands_by_code[0], commands_by_code[1], commands_by_code[2]);
        $display("%0d tail, %0d head, %0d key removes; %0d unused codes.",
                 commands_by_code[3], commands_by_code[4], commands_by_code[5],
                 commands_by_code[6] + commands_by_code[7]);
        $write("Checked %0d results, peak occupancy %0d, ", results_checked, peak_occupancy);
        $display("refused full %0d, empty %0d, key missing %0d.",
                 status_seen[ST_FULL], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND]);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
